/* src/frac_n_pll_divider_calc_defines.svh */
// Assertion helpers shared by the divider calculator.
`ifndef FRAC_N_PLL_DIVIDER_CALC_DEFINES_SVH
`define FRAC_N_PLL_DIVIDER_CALC_DEFINES_SVH

// Concurrent check that is switched off while reset is high.
`define FNPLL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define FNPLL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/fnpll_pkg.sv */
package fnpll_pkg;

   // Field widths.
   localparam int TARGET_W    = 33;
   localparam int PFD_W       = 27;
   localparam int AUX_W       = 14;
   localparam int INT_W       = 13;
   localparam int MAIN_MOD_W  = 24;
   localparam int SEL_W       = 3;
   localparam int CSR_IDX_W   = 8;

   // Long division of vco * 2^24 yields the integer part and main fraction.
   localparam int QUO_W       = TARGET_W + MAIN_MOD_W;
   localparam int PROD_W      = PFD_W + AUX_W;
   localparam int DIV1_STEPS  = QUO_W;
   localparam int DIV2_STEPS  = AUX_W;

   // Band edges: the lowest band starts at 53.125 MHz.
   localparam logic [TARGET_W-1:0] BAND_BASE_HZ = TARGET_W'(64'd53125000);
   localparam int TOP_SELECT  = 6;
   localparam logic [SEL_W-1:0] TOP_SEL = SEL_W'(TOP_SELECT);
   localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PFD_IDX = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AUX_IDX = CSR_IDX_W'(1);

   localparam logic [PFD_W-1:0] PFD_RESET = PFD_W'(10000000);
   localparam logic [AUX_W-1:0] AUX_RESET = AUX_W'(16383);

   // One pipeline stage worth of state.
   typedef struct packed {
      logic                  valid;
      logic [PFD_W-1:0]      rem;
      logic [QUO_W-1:0]      quo;
      logic [SEL_W-1:0]      sel;
      logic                  in_range;
      logic [INT_W-1:0]      ip;
      logic [MAIN_MOD_W-1:0] f1;
   } stage_type;

   // Lower edge of band j in hertz, j = 0 is the lowest band.
   function automatic logic [TARGET_W-1:0] band_low(input int j);
      band_low = TARGET_W'({31'd0, BAND_BASE_HZ} << j);
   endfunction

endpackage

/* src/fnpll_band.sv */
module fnpll_band (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                take,
   input  logic [fnpll_pkg::TARGET_W-1:0]      target,
   output fnpll_pkg::stage_type                stg_ff
);

   fnpll_pkg::stage_type stg_in;
   logic [fnpll_pkg::SEL_W-1:0] sel;
   logic found;

   // Find the octave band; each band check is an independent compare.
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int j = 0; j <= fnpll_pkg::TOP_SELECT; j++) begin
         if (target >= fnpll_pkg::band_low(j) && target < fnpll_pkg::band_low(j + 1)) begin
            sel   = fnpll_pkg::TOP_SEL - fnpll_pkg::SEL_W'(j);
            found = 1'b1;
         end
      end
   end

   // Seed the long division with vco followed by the fraction zeros.
   always_comb begin
      stg_in          = '0;
      stg_in.valid    = take;
      stg_in.in_range = found;
      stg_in.sel      = sel;
      stg_in.quo      = {target << sel, {fnpll_pkg::MAIN_MOD_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.valid <= 1'b0;
      end else if (en) begin
         stg_ff <= stg_in;
      end
   end

endmodule

/* src/fnpll_div_stage.sv */
module fnpll_div_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [fnpll_pkg::PFD_W-1:0]    pfd,
   input  fnpll_pkg::stage_type           stg_prev,
   output fnpll_pkg::stage_type           stg_ff
);

   fnpll_pkg::stage_type stg_in;
   logic [fnpll_pkg::PFD_W:0] trial;
   logic fits;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   always_comb begin
      trial      = {stg_prev.rem, stg_prev.quo[fnpll_pkg::QUO_W-1]};
      fits       = trial >= {1'b0, pfd};
      stg_in     = stg_prev;
      stg_in.rem = fits ? fnpll_pkg::PFD_W'(trial - {1'b0, pfd})
                        : trial[fnpll_pkg::PFD_W-1:0];
      stg_in.quo = {stg_prev.quo[fnpll_pkg::QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.valid <= 1'b0;
      end else if (en) begin
         stg_ff <= stg_in;
      end
   end

endmodule

/* src/fnpll_mul.sv */
module fnpll_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [fnpll_pkg::AUX_W-1:0]    aux,
   input  fnpll_pkg::stage_type           stg_prev,
   output fnpll_pkg::stage_type           stg_ff
);

   fnpll_pkg::stage_type stg_in;
   logic [fnpll_pkg::PROD_W-1:0] prod;
   logic [fnpll_pkg::TARGET_W-1:0] ip_raw;

   // Split the first quotient, then scale the remainder by the aux modulus.
   // The product over 2^14 is below pfd, so its top bits seed the second division.
   always_comb begin
      ip_raw     = stg_prev.quo[fnpll_pkg::QUO_W-1:fnpll_pkg::MAIN_MOD_W];
      prod       = fnpll_pkg::PROD_W'(stg_prev.rem) * fnpll_pkg::PROD_W'(aux);
      stg_in     = stg_prev;
      stg_in.ip  = (ip_raw > fnpll_pkg::TARGET_W'(fnpll_pkg::INT_MAX))
                   ? fnpll_pkg::INT_MAX : ip_raw[fnpll_pkg::INT_W-1:0];
      stg_in.f1  = stg_prev.quo[fnpll_pkg::MAIN_MOD_W-1:0];
      stg_in.rem = prod[fnpll_pkg::PROD_W-1:fnpll_pkg::AUX_W];
      stg_in.quo = {prod[fnpll_pkg::AUX_W-1:0],
                    {(fnpll_pkg::QUO_W - fnpll_pkg::AUX_W){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.valid <= 1'b0;
      end else if (en) begin
         stg_ff <= stg_in;
      end
   end

endmodule

/* src/frac_n_pll_divider_calc.sv */
// Fractional-N PLL divider calculator.
// The req_ channel takes a target frequency in hertz; the rsp_ channel returns
// the integer part, the 2^24 main fraction, the auxiliary fraction, the output
// divider exponent and an in-range flag, one result transaction per request.
// The csr_ channel writes the PFD frequency (index 0) and auxiliary modulus
// (index 1); it is always ready and other indexes are ignored. Write it only
// while no request is in flight.
// The pipeline has one band-select stage, 57 restoring division steps (one
// quotient bit per stage), one multiply stage and 14 more division steps.
// A new request is taken every cycle unless the result is stalled, so the
// throughput is one transaction per clock.
// When rsp_ready is low while a result is shown, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated. Synchronous reset empties the
// pipeline and restores the PFD to 10 MHz and the auxiliary modulus to 16383.
`include "frac_n_pll_divider_calc_defines.svh"

module frac_n_pll_divider_calc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fnpll_pkg::TARGET_W-1:0]       req_target_frequency_hz,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fnpll_pkg::INT_W-1:0]          rsp_integer_part,
   output logic [fnpll_pkg::MAIN_MOD_W-1:0]     rsp_main_fraction,
   output logic [fnpll_pkg::AUX_W-1:0]          rsp_aux_fraction,
   output logic [fnpll_pkg::SEL_W-1:0]          rsp_divider_select,
   output logic                                 rsp_in_range,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fnpll_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fnpll_pkg::PFD_W-1:0]          csr_data
);

   logic [fnpll_pkg::PFD_W-1:0] pfd_ff;
   logic [fnpll_pkg::AUX_W-1:0] aux_ff;
   logic en;
   logic pfd_zero;
   fnpll_pkg::stage_type div1_stg [0:fnpll_pkg::DIV1_STEPS];
   fnpll_pkg::stage_type div2_stg [0:fnpll_pkg::DIV2_STEPS];
   fnpll_pkg::stage_type last;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pfd_ff <= fnpll_pkg::PFD_RESET;
         aux_ff <= fnpll_pkg::AUX_RESET;
      end else if (csr_valid) begin
         if (csr_index == fnpll_pkg::CSR_PFD_IDX) begin
            pfd_ff <= csr_data;
         end else if (csr_index == fnpll_pkg::CSR_AUX_IDX) begin
            aux_ff <= csr_data[fnpll_pkg::AUX_W-1:0];
         end
      end
   end

   // The pipeline advances as a whole unless a shown result is stalled.
   assign en        = !last.valid || rsp_ready;
   assign req_ready = en;

   fnpll_band u_band (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .take   (req_valid),
      .target (req_target_frequency_hz),
      .stg_ff (div1_stg[0])
   );

   // First long division: vco * 2^24 over pfd.
   for (genvar i = 0; i < fnpll_pkg::DIV1_STEPS; i++) begin : g_div1
      fnpll_div_stage u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .pfd      (pfd_ff),
         .stg_prev (div1_stg[i]),
         .stg_ff   (div1_stg[i+1])
      );
   end

   fnpll_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .aux      (aux_ff),
      .stg_prev (div1_stg[fnpll_pkg::DIV1_STEPS]),
      .stg_ff   (div2_stg[0])
   );

   // Second long division: remainder times aux modulus over pfd.
   for (genvar i = 0; i < fnpll_pkg::DIV2_STEPS; i++) begin : g_div2
      fnpll_div_stage u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .pfd      (pfd_ff),
         .stg_prev (div2_stg[i]),
         .stg_ff   (div2_stg[i+1])
      );
   end

   assign last = div2_stg[fnpll_pkg::DIV2_STEPS];

   // Result fields; out of band or a zero PFD clears the divide words.
   assign pfd_zero           = (pfd_ff == '0);
   assign rsp_valid          = last.valid;
   assign rsp_in_range       = last.in_range;
   assign rsp_divider_select = last.in_range ? last.sel : '0;
   assign rsp_integer_part   = (last.in_range && !pfd_zero) ? last.ip : '0;
   assign rsp_main_fraction  = (last.in_range && !pfd_zero) ? last.f1 : '0;
   assign rsp_aux_fraction   = (last.in_range && !pfd_zero)
                               ? last.quo[fnpll_pkg::AUX_W-1:0] : '0;

   // Checks on the result path.
   `FNPLL_ASSERT(a_out_of_band_zero, clock, reset,
      rsp_valid && !rsp_in_range |-> rsp_integer_part == '0 && rsp_main_fraction == '0
         && rsp_aux_fraction == '0 && rsp_divider_select == '0,
      "out-of-band result is not all zero")
   `FNPLL_ASSERT(a_aux_below_modulus, clock, reset,
      rsp_valid && aux_ff != '0 |-> rsp_aux_fraction < aux_ff,
      "aux fraction not below modulus")
   `FNPLL_ASSERT(a_sel_range, clock, reset,
      rsp_valid && rsp_in_range |-> rsp_divider_select <= fnpll_pkg::TOP_SEL,
      "divider select out of range")
   `FNPLL_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_valid,
      "result valid right after reset")

endmodule
